### design/lsms_pkg.sv
package lsms_pkg;

    localparam int NUM_COLUMNS  = 8;
    localparam int SAMPLE_BITS  = 10;
    localparam int SWITCH_A_POS = 13;
    localparam int SWITCH_B_POS = 14;
    localparam int LEVEL_W      = 15;
    localparam int STORE_DEPTH  = 8;
    localparam int CHAN_W       = 3;
    localparam int SAMPLE_W     = 10;

    localparam logic [7:0] LED_ON_RESET = 8'd8;
    localparam logic [7:0] SINK_RESET   = 8'hFE;

    typedef logic [1:0]         op_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [CHAN_W-1:0]  chan_t;

    localparam op_t OP_TICK  = 2'd0;
    localparam op_t OP_LED   = 2'd1;
    localparam op_t OP_STORE = 2'd2;
    localparam op_t OP_READ  = 2'd3;

    typedef struct packed {
        logic [7:0]             sink;
        logic                   led_on;
        logic [NUM_COLUMNS-1:0] sw_a;
        logic [NUM_COLUMNS-1:0] sw_b;
    } scan_status_t;

endpackage

### design/lsms_scan.sv
module lsms_scan
    import lsms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         tick_en,
    input  logic         sense_a,
    input  logic         sense_b,
    input  logic         led_wr_en,
    input  logic [7:0]   led_pattern,
    input  logic [7:0]   led_on_ticks,
    output scan_status_t status
);

    logic [7:0]             phase_reg, phase_next;
    logic [7:0]             led_bits_reg, led_bits_next;
    logic [7:0]             sink_reg, sink_next;
    logic                   led_on_reg, led_on_next;
    logic [NUM_COLUMNS-1:0] sw_a_reg, sw_a_next;
    logic [NUM_COLUMNS-1:0] sw_b_reg, sw_b_next;

    always_comb
    begin
        logic [7:0]             offset;
        logic [7:0]             idx;
        logic [7:0]             onehot;
        logic [NUM_COLUMNS-1:0] col;
        logic                   in_a;
        logic                   in_b;

        offset = phase_reg - led_on_ticks - 8'd1;
        in_a   = (phase_reg > led_on_ticks) && (offset < 8'(NUM_COLUMNS));
        in_b   = (phase_reg > led_on_ticks) && (offset >= 8'(NUM_COLUMNS))
                 && ((offset - 8'(NUM_COLUMNS)) < 8'(NUM_COLUMNS));
        idx    = in_a ? offset : (offset - 8'(NUM_COLUMNS));
        onehot = 8'd1 << idx;
        col    = onehot[NUM_COLUMNS-1:0];

        phase_next    = phase_reg;
        led_bits_next = led_bits_reg;
        sink_next     = sink_reg;
        led_on_next   = led_on_reg;
        sw_a_next     = sw_a_reg;
        sw_b_next     = sw_b_reg;

        if (led_wr_en)
        begin
            led_bits_next = led_pattern;
        end

        if (tick_en)
        begin
            phase_next = phase_reg + 8'd1;
            if (phase_reg == 8'd0)
            begin
                sink_next   = ~led_bits_reg;
                led_on_next = 1'b1;
            end
            else if (phase_reg == led_on_ticks)
            begin
                led_on_next = 1'b0;
            end
            else if (in_a)
            begin
                sink_next = ~onehot;
                sw_a_next = sense_a ? (sw_a_reg & ~col) : (sw_a_reg | col);
            end
            else if (in_b)
            begin
                sink_next = ~onehot;
                sw_b_next = sense_b ? (sw_b_reg & ~col) : (sw_b_reg | col);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            led_bits_reg <= '0;
            sink_reg     <= SINK_RESET;
            led_on_reg   <= 1'b0;
            sw_a_reg     <= '0;
            sw_b_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            led_bits_reg <= led_bits_next;
            sink_reg     <= sink_next;
            led_on_reg   <= led_on_next;
            sw_a_reg     <= sw_a_next;
            sw_b_reg     <= sw_b_next;
        end
    end

    assign status.sink   = sink_next;
    assign status.led_on = led_on_next;
    assign status.sw_a   = sw_a_reg;
    assign status.sw_b   = sw_b_reg;

endmodule

### design/lsms_level_store.sv
module lsms_level_store
    import lsms_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  chan_t  wr_index,
    input  level_t wr_data,
    input  chan_t  rd_index,
    output level_t rd_data
);

    level_t store_reg [STORE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STORE_DEPTH; k++)
            begin
                store_reg[k] <= '0;
            end
        end
        else if (wr_en)
        begin
            store_reg[wr_index] <= wr_data;
        end
    end

    assign rd_data = store_reg[rd_index];

endmodule

### design/led_switch_matrix_scanner.sv
// Scanner for an eight-column LED and two-row switch matrix with a small
// store of tagged converter levels. One request is taken per clock while the
// result side keeps up: it is held in an input register, decoded and applied
// once the output register is free or being emptied, and its result waits in
// the output register until it is taken. Request kind in s_axis_tuser: tick,
// LED pattern write, sample store, level read. Every request yields one
// result carrying the sink drive and LED enable after that request; the level
// and the read flag are set only for a level read. The LED on-time is written
// through cfg_we/cfg_wdata; the user must write it only while no request is
// in flight, and the block itself does not enforce this. It resets to 8.
module led_switch_matrix_scanner
    import lsms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // sense_a, sense_b, led_pattern[7:0],
                                       // channel_index[2:0], sample[9:0], pad
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // sink_drive[7:0], led_enable,
                                       // level_value[14:0]
    output logic [0:0]  m_axis_tuser   // read_valid
);

    logic [7:0] led_on_ticks_reg;

    logic                in_valid_reg, in_valid_next;
    op_t                 in_op_reg;
    logic                in_sa_reg;
    logic                in_sb_reg;
    logic [7:0]          in_pat_reg;
    chan_t               in_ch_reg;
    logic [SAMPLE_W-1:0] in_smp_reg;

    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg;
    logic        out_user_reg;

    logic         advance;
    logic         in_take;
    logic         tick_en;
    logic         led_wr_en;
    logic         store_en;
    logic         read_sel;
    scan_status_t status;
    level_t       wr_level;
    level_t       rd_level;
    level_t       level_out;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        tick_en   = 1'b0;
        led_wr_en = 1'b0;
        store_en  = 1'b0;
        read_sel  = 1'b0;
        unique case (in_op_reg)
            OP_TICK:  tick_en   = advance;
            OP_LED:   led_wr_en = advance;
            OP_STORE: store_en  = advance;
            OP_READ:  read_sel  = 1'b1;
            default:  read_sel  = 1'b0;
        endcase
    end

    always_comb
    begin
        logic [7:0]   a_bits;
        logic [7:0]   b_bits;
        logic [LEVEL_W-1:0] smp_ext;

        a_bits  = 8'(status.sw_a);
        b_bits  = 8'(status.sw_b);
        smp_ext = LEVEL_W'(in_smp_reg);
        wr_level = '0;
        wr_level[SAMPLE_BITS-1:0] = smp_ext[SAMPLE_BITS-1:0];
        wr_level[SWITCH_A_POS]    = a_bits[in_ch_reg];
        wr_level[SWITCH_B_POS]    = b_bits[in_ch_reg];
    end

    lsms_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_en      (tick_en),
        .sense_a      (in_sa_reg),
        .sense_b      (in_sb_reg),
        .led_wr_en    (led_wr_en),
        .led_pattern  (in_pat_reg),
        .led_on_ticks (led_on_ticks_reg),
        .status       (status)
    );

    lsms_level_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (store_en),
        .wr_index (in_ch_reg),
        .wr_data  (wr_level),
        .rd_index (in_ch_reg),
        .rd_data  (rd_level)
    );

    assign level_out = read_sel ? rd_level : '0;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_on_ticks_reg <= LED_ON_RESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                led_on_ticks_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg  <= s_axis_tuser;
            in_sa_reg  <= s_axis_tdata[0];
            in_sb_reg  <= s_axis_tdata[1];
            in_pat_reg <= s_axis_tdata[9:2];
            in_ch_reg  <= s_axis_tdata[12:10];
            in_smp_reg <= s_axis_tdata[22:13];
        end
        if (advance)
        begin
            out_data_reg <= {level_out, status.led_on, status.sink};
            out_user_reg <= read_sel;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_user_reg;

endmodule
